// ===== rtl/tdf_pkg.sv =====
package tdf_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned SqW    = 2 * DataW;
  localparam int unsigned PcW    = 4;

  typedef logic [PcW-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_EMIT_NEG,
    OP_EMIT_TWO,
    OP_INIT_D,
    OP_DIV_START,
    OP_EMIT_D,
    OP_ADV_D,
    OP_EMIT_REM,
    OP_EMIT_EMPTY
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_REM_LE1,
    C_POS,
    C_REM_ODD,
    C_SQ_GT,
    C_DIV_BUSY,
    C_DIV_NZ
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } ucode_t;

  localparam pc_t S_IDLE      = pc_t'(0);
  localparam pc_t S_CHK_TRIV  = pc_t'(1);
  localparam pc_t S_CHK_NEG   = pc_t'(2);
  localparam pc_t S_EMIT_NEG  = pc_t'(3);
  localparam pc_t S_TWO       = pc_t'(4);
  localparam pc_t S_EMIT_TWO  = pc_t'(5);
  localparam pc_t S_ODD_INIT  = pc_t'(6);
  localparam pc_t S_LOOP      = pc_t'(7);
  localparam pc_t S_DIV_START = pc_t'(8);
  localparam pc_t S_DIV_RUN   = pc_t'(9);
  localparam pc_t S_DIV_CHK   = pc_t'(10);
  localparam pc_t S_EMIT_D    = pc_t'(11);
  localparam pc_t S_NEXT_D    = pc_t'(12);
  localparam pc_t S_TAIL      = pc_t'(13);
  localparam pc_t S_EMIT_REM  = pc_t'(14);
  localparam pc_t S_EMPTY     = pc_t'(15);

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    unique case (pc)
      S_IDLE:      w = '{op: OP_LOAD,       cond: C_NO_IN,    target: S_IDLE};
      S_CHK_TRIV:  w = '{op: OP_NOP,        cond: C_REM_LE1,  target: S_EMPTY};
      S_CHK_NEG:   w = '{op: OP_NOP,        cond: C_POS,      target: S_TWO};
      S_EMIT_NEG:  w = '{op: OP_EMIT_NEG,   cond: C_NEVER,    target: S_IDLE};
      S_TWO:       w = '{op: OP_NOP,        cond: C_REM_ODD,  target: S_ODD_INIT};
      S_EMIT_TWO:  w = '{op: OP_EMIT_TWO,   cond: C_ALWAYS,   target: S_TWO};
      S_ODD_INIT:  w = '{op: OP_INIT_D,     cond: C_NEVER,    target: S_IDLE};
      S_LOOP:      w = '{op: OP_NOP,        cond: C_SQ_GT,    target: S_TAIL};
      S_DIV_START: w = '{op: OP_DIV_START,  cond: C_NEVER,    target: S_IDLE};
      S_DIV_RUN:   w = '{op: OP_NOP,        cond: C_DIV_BUSY, target: S_DIV_RUN};
      S_DIV_CHK:   w = '{op: OP_NOP,        cond: C_DIV_NZ,   target: S_NEXT_D};
      S_EMIT_D:    w = '{op: OP_EMIT_D,     cond: C_ALWAYS,   target: S_DIV_START};
      S_NEXT_D:    w = '{op: OP_ADV_D,      cond: C_ALWAYS,   target: S_LOOP};
      S_TAIL:      w = '{op: OP_NOP,        cond: C_REM_LE1,  target: S_IDLE};
      S_EMIT_REM:  w = '{op: OP_EMIT_REM,   cond: C_ALWAYS,   target: S_IDLE};
      S_EMPTY:     w = '{op: OP_EMIT_EMPTY, cond: C_ALWAYS,   target: S_IDLE};
      default:     w = '{op: OP_NOP,        cond: C_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/tdf_div.sv =====
module tdf_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [tdf_pkg::DataW-1:0]      dividend_i,
  input  logic [tdf_pkg::DataW-1:0]      divisor_i,
  output logic [tdf_pkg::DataW-1:0]      quot_o,
  output logic [tdf_pkg::DataW-1:0]      rem_o
);

  localparam int unsigned W    = tdf_pkg::DataW;
  localparam int unsigned CntW = $clog2(W + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    acc_q, acc_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    dvs_q, dvs_d;
  logic [W:0]      trial;
  logic [W:0]      diff;

  always_comb begin
    trial = {acc_q, quo_q[W-1]};
    diff  = trial - {1'b0, dvs_q};
    cnt_d = cnt_q;
    acc_d = acc_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    if (start_i) begin
      cnt_d = CntW'(W);
      acc_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CntW'(1);
      acc_d = diff[W] ? trial[W-1:0] : diff[W-1:0];
      quo_d = {quo_q[W-2:0], ~diff[W]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quo_q;
  assign rem_o  = acc_q;

endmodule

// ===== rtl/trial_division_factorizer_core.sv =====
// Trial-division prime factorizer.
// Input channel (in_valid_i / in_ready_o, value_i): one signed 32-bit integer
// per beat. Output channel (out_valid_o / out_ready_i): one beat per prime
// factor in ascending order, repeats included; a negative input first yields
// factor -1. Inputs 0, 1 and -1 yield a single beat with empty_res_o set.
// last_o marks the final beat of each input.
// One input is worked at a time; in_ready_o is high only while idle.
// Control is a 16-step microcode program; each odd trial divisor that does not
// divide takes the loop check, the division start, a wait on the 32-step
// restoring division, the remainder check and the divisor advance, so the
// run time of an input grows with the number of odd divisors up to sqrt of the
// remainder; it is longest for a prime near 2^31, short for small or smooth inputs.
// Results sit in an output register; while the receiver stalls, the
// sequencer holds at its next emit step. Reset clears the sequencer to idle
// and empties the output register.
module trial_division_factorizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] factor_o,
  output logic        empty_res_o,
  output logic        last_o
);

  localparam int unsigned W  = tdf_pkg::DataW;
  localparam int unsigned SW = tdf_pkg::SqW;

  tdf_pkg::pc_t       pc_q, pc_d;
  tdf_pkg::ucode_t    uw;
  logic               div_start;
  logic               div_busy;

  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  d_q, d_d;
  logic [SW-1:0] sq_q, sq_d;
  logic          neg_q, neg_d;

  logic          out_valid_q, out_valid_d;
  logic [W-1:0]  factor_q, factor_d;
  logic          empty_q, empty_d;
  logic          last_q, last_d;

  logic [W-1:0]  div_quot;
  logic [W-1:0]  div_rem;
  logic [W-1:0]  mag;
  logic          is_emit;
  logic          stall;
  logic          cond_true;
  logic          in_acc;

  assign uw         = tdf_pkg::ucode_rom(pc_q);
  assign in_ready_o = (pc_q == tdf_pkg::S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign mag        = value_i[W-1] ? (W'(0) - value_i) : value_i;

  assign is_emit = (uw.op == tdf_pkg::OP_EMIT_NEG) || (uw.op == tdf_pkg::OP_EMIT_TWO) ||
                   (uw.op == tdf_pkg::OP_EMIT_D) || (uw.op == tdf_pkg::OP_EMIT_REM) ||
                   (uw.op == tdf_pkg::OP_EMIT_EMPTY);
  assign stall   = is_emit && out_valid_q && !out_ready_i;

  assign div_start = (uw.op == tdf_pkg::OP_DIV_START);

  tdf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .busy_o     (div_busy),
    .dividend_i (rem_q),
    .divisor_i  (d_q),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    unique case (uw.cond)
      tdf_pkg::C_NEVER:    cond_true = 1'b0;
      tdf_pkg::C_ALWAYS:   cond_true = 1'b1;
      tdf_pkg::C_NO_IN:    cond_true = !in_valid_i;
      tdf_pkg::C_REM_LE1:  cond_true = (rem_q <= W'(1));
      tdf_pkg::C_POS:      cond_true = !neg_q;
      tdf_pkg::C_REM_ODD:  cond_true = rem_q[0];
      tdf_pkg::C_SQ_GT:    cond_true = (sq_q > SW'(rem_q));
      tdf_pkg::C_DIV_BUSY: cond_true = div_busy;
      tdf_pkg::C_DIV_NZ:   cond_true = (div_rem != '0);
      default:             cond_true = 1'b0;
    endcase
  end

  always_comb begin
    pc_d        = pc_q;
    rem_d       = rem_q;
    d_d         = d_q;
    sq_d        = sq_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    factor_d    = factor_q;
    empty_d     = empty_q;
    last_d      = last_q;

    if (!stall) begin
      pc_d = cond_true ? uw.target : pc_q + tdf_pkg::pc_t'(1);
      if (is_emit) begin
        out_valid_d = 1'b1;
        empty_d     = 1'b0;
        last_d      = 1'b0;
      end
      unique case (uw.op)
        tdf_pkg::OP_LOAD: begin
          if (in_acc) begin
            rem_d = mag;
            neg_d = value_i[W-1];
          end
        end
        tdf_pkg::OP_EMIT_NEG: begin
          factor_d = '1;
        end
        tdf_pkg::OP_EMIT_TWO: begin
          factor_d = W'(2);
          rem_d    = rem_q >> 1;
          last_d   = ((rem_q >> 1) == W'(1));
        end
        tdf_pkg::OP_INIT_D: begin
          d_d  = W'(3);
          sq_d = SW'(9);
        end
        tdf_pkg::OP_EMIT_D: begin
          factor_d = d_q;
          rem_d    = div_quot;
          last_d   = (div_quot == W'(1));
        end
        tdf_pkg::OP_ADV_D: begin
          d_d  = d_q + W'(2);
          sq_d = sq_q + (SW'(d_q) << 2) + SW'(4);
        end
        tdf_pkg::OP_EMIT_REM: begin
          factor_d = rem_q;
          last_d   = 1'b1;
        end
        tdf_pkg::OP_EMIT_EMPTY: begin
          factor_d = '0;
          empty_d  = 1'b1;
          last_d   = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= tdf_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
      d_q         <= W'(3);
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
      d_q         <= d_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q     <= sq_d;
    neg_q    <= neg_d;
    factor_q <= factor_d;
    empty_q  <= empty_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign factor_o    = factor_q;
  assign empty_res_o = empty_q;
  assign last_o      = last_q;

  a_load_then_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (pc_q == tdf_pkg::S_CHK_TRIV))
    else $error("input beat not followed by trivial check");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_res_o) |-> last_o)
    else $error("empty result without last");

  a_loop_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == tdf_pkg::S_LOOP) |-> (rem_q[0] && d_q[0] && (d_q >= W'(3))))
    else $error("remainder or divisor not odd in divisor loop");

  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == tdf_pkg::S_DIV_START) |-> !div_busy)
    else $error("division started while busy");

  a_div_done_at_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == tdf_pkg::S_DIV_CHK) |-> (!div_busy && $past(pc_q) == tdf_pkg::S_DIV_RUN))
    else $error("division result checked before completion");

endmodule
